/* design/pbws_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbws_pkg
// Shared types and constants of the protocol-buffer wire field scanner.
// ----------------------------------------------------------------------------
package pbws_pkg;

  localparam int unsigned APB_ADDR_W = 3;
  localparam logic [APB_ADDR_W-1:0] ADDR_MAX_LENGTH = 3'd0;
  localparam logic [31:0] MAX_LENGTH_RESET = 32'hFFFF_FFFF;

  typedef logic [2:0] kind_t;
  localparam kind_t KIND_VARINT = 3'd0;
  localparam kind_t KIND_FIX64  = 3'd1;
  localparam kind_t KIND_HEADER = 3'd2;
  localparam kind_t KIND_FIX32  = 3'd3;
  localparam kind_t KIND_BYTE   = 3'd4;
  localparam kind_t KIND_ERROR  = 3'd5;

  typedef logic [2:0] err_t;
  localparam err_t ERR_NONE   = 3'd0;
  localparam err_t ERR_TRUNC  = 3'd1;
  localparam err_t ERR_LONG   = 3'd2;
  localparam err_t ERR_NUMBER = 3'd3;
  localparam err_t ERR_WIRE   = 3'd4;
  localparam err_t ERR_LENGTH = 3'd5;

  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_FIX64  = 3'd1;
  localparam logic [2:0] WIRE_LEN    = 3'd2;
  localparam logic [2:0] WIRE_FIX32  = 3'd5;

  localparam logic [31:0] FIX64_BYTES = 32'd8;
  localparam logic [31:0] FIX32_BYTES = 32'd4;
  localparam logic [3:0]  VARINT_LAST_IDX = 4'd9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_word_t;

  typedef struct packed {
    kind_t       kind;
    logic [28:0] field_number;
    logic [2:0]  wire_type;
    logic [63:0] field_value;
    logic        payload_last;
    err_t        error_code;
    logic        buffer_done;
  } result_t;

endpackage
`default_nettype wire

/* design/pbws_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbws_if
// Valid/ready channels for input bytes and scanner results.
// ----------------------------------------------------------------------------
interface pbws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, data_byte, end_of_buffer, input ready);
  modport sink (input valid, data_byte, end_of_buffer, output ready);
endinterface

interface pbws_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [28:0] field_number;
  logic [2:0]  wire_type;
  logic [63:0] field_value;
  logic        payload_last;
  logic [2:0]  error_code;
  logic        buffer_done;

  modport source (output valid, kind, field_number, wire_type, field_value, payload_last,
                  error_code, buffer_done, input ready);
  modport sink (input valid, kind, field_number, wire_type, field_value, payload_last,
                error_code, buffer_done, output ready);
endinterface
`default_nettype wire

/* design/pbws_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbws_cfg
// APB register file holding the maximum admitted length.
// ----------------------------------------------------------------------------
module pbws_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pbws_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  output logic      [31:0]                     max_length
);

  logic wr_en;
  logic sel_max_length;

  assign pready = 1'b1;
  assign sel_max_length = (paddr[pbws_pkg::APB_ADDR_W-1:2] ==
                           pbws_pkg::ADDR_MAX_LENGTH[pbws_pkg::APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && sel_max_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= pbws_pkg::MAX_LENGTH_RESET;
    end else if (wr_en) begin
      max_length <= pwdata;
    end
  end

  assign prdata = sel_max_length ? max_length : 32'd0;

endmodule
`default_nettype wire

/* design/pbws_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbws_core
// Scanner state and the per-byte step: varint decode, field phases, errors.
// ----------------------------------------------------------------------------
module pbws_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire pbws_pkg::in_word_t in_word,
  input  wire logic [31:0]        max_length,
  output logic                    res_valid,
  output pbws_pkg::result_t       res
);

  typedef enum logic [2:0] {
    PH_KEY,
    PH_VALUE,
    PH_FIXED,
    PH_LENGTH,
    PH_PAYLOAD
  } phase_t;

  phase_t      phase, phase_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  vcount, vcount_next;
  logic [28:0] cur_field, cur_field_next;
  logic [2:0]  cur_wire, cur_wire_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic        error_hold, error_hold_next;

  logic        eob;
  logic [7:0]  b;
  logic [5:0]  shamt;
  logic [63:0] acc_v;
  logic [3:0]  vcount_v;
  logic        v_done, v_bad;
  logic [31:0] bl_dec;
  logic [2:0]  key_wire;
  logic        do_fin, do_fail, do_emit, do_clear;
  pbws_pkg::err_t  fail_code;
  pbws_pkg::kind_t out_kind;
  logic [63:0] out_value;
  logic        out_last;

  assign eob   = in_word.end_of_buffer;
  assign b     = in_word.data_byte;
  assign shamt = {2'b00, vcount} * 6'd7;
  assign bl_dec = (bytes_left != 32'd0) ? bytes_left - 32'd1 : 32'd0;
  assign key_wire = acc_v[2:0];

  // One varint byte folded into the accumulator.
  always_comb begin
    if (vcount >= pbws_pkg::VARINT_LAST_IDX) begin
      v_bad    = (b[7:1] != 7'd0);
      v_done   = !v_bad;
      acc_v    = acc | {b[0], 63'd0};
      vcount_v = 4'd0;
    end else begin
      v_bad    = 1'b0;
      v_done   = !b[7];
      acc_v    = acc | ({57'd0, b[6:0]} << shamt);
      vcount_v = v_done ? 4'd0 : vcount + 4'd1;
    end
  end

  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    vcount_next     = vcount;
    cur_field_next  = cur_field;
    cur_wire_next   = cur_wire;
    bytes_left_next = bytes_left;
    error_hold_next = error_hold;
    do_fin    = 1'b0;
    do_fail   = 1'b0;
    do_emit   = 1'b0;
    do_clear  = 1'b0;
    fail_code = pbws_pkg::ERR_NONE;
    out_kind  = pbws_pkg::KIND_VARINT;
    out_value = 64'd0;
    out_last  = 1'b0;

    if (fire) begin
      if (error_hold) begin
        do_clear = eob;
      end else if (phase == PH_FIXED || phase == PH_PAYLOAD) begin
        if (bl_dec == 32'd0) begin
          do_fin = 1'b1;
          if (phase == PH_PAYLOAD) begin
            out_kind  = pbws_pkg::KIND_BYTE;
            out_value = {56'd0, b};
            out_last  = 1'b1;
          end else begin
            out_kind = (cur_wire == pbws_pkg::WIRE_FIX64) ? pbws_pkg::KIND_FIX64
                                                         : pbws_pkg::KIND_FIX32;
          end
        end else if (eob) begin
          do_fail   = 1'b1;
          fail_code = pbws_pkg::ERR_TRUNC;
        end else begin
          bytes_left_next = bl_dec;
          if (phase == PH_PAYLOAD) begin
            do_emit   = 1'b1;
            out_kind  = pbws_pkg::KIND_BYTE;
            out_value = {56'd0, b};
          end
        end
      end else begin
        acc_next    = acc_v;
        vcount_next = vcount_v;
        if (v_bad) begin
          do_fail   = 1'b1;
          fail_code = pbws_pkg::ERR_LONG;
        end else if (!v_done) begin
          if (eob) begin
            do_fail   = 1'b1;
            fail_code = pbws_pkg::ERR_TRUNC;
          end
        end else begin
          case (phase)
            PH_VALUE: begin
              do_fin    = 1'b1;
              out_kind  = pbws_pkg::KIND_VARINT;
              out_value = acc_v;
            end
            PH_LENGTH: begin
              acc_next = 64'd0;
              out_kind = pbws_pkg::KIND_HEADER;
              if (acc_v[63:32] != 32'd0 || acc_v[31:0] > max_length) begin
                do_fail   = 1'b1;
                fail_code = pbws_pkg::ERR_LENGTH;
              end else if (acc_v == 64'd0) begin
                do_fin = 1'b1;
              end else if (eob) begin
                do_fail   = 1'b1;
                fail_code = pbws_pkg::ERR_TRUNC;
              end else begin
                do_emit         = 1'b1;
                out_value       = acc_v;
                bytes_left_next = acc_v[31:0];
                phase_next      = PH_PAYLOAD;
              end
            end
            default: begin
              acc_next = 64'd0;
              if (acc_v[63:3] == 61'd0 || acc_v[63:32] != 32'd0) begin
                do_fail   = 1'b1;
                fail_code = pbws_pkg::ERR_NUMBER;
              end else if (!(key_wire inside {pbws_pkg::WIRE_VARINT, pbws_pkg::WIRE_FIX64,
                                              pbws_pkg::WIRE_LEN, pbws_pkg::WIRE_FIX32})) begin
                do_fail   = 1'b1;
                fail_code = pbws_pkg::ERR_WIRE;
              end else if (eob) begin
                do_fail   = 1'b1;
                fail_code = pbws_pkg::ERR_TRUNC;
              end else begin
                cur_field_next = acc_v[31:3];
                cur_wire_next  = key_wire;
                if (key_wire == pbws_pkg::WIRE_VARINT) begin
                  phase_next = PH_VALUE;
                end else if (key_wire == pbws_pkg::WIRE_LEN) begin
                  phase_next = PH_LENGTH;
                end else begin
                  phase_next      = PH_FIXED;
                  bytes_left_next = (key_wire == pbws_pkg::WIRE_FIX64) ? pbws_pkg::FIX64_BYTES
                                                                       : pbws_pkg::FIX32_BYTES;
                end
              end
            end
          endcase
        end
      end
    end

    if (do_fin) begin
      if (eob) begin
        do_clear = 1'b1;
      end else begin
        phase_next      = PH_KEY;
        acc_next        = 64'd0;
        bytes_left_next = 32'd0;
      end
    end
    if (do_fail) begin
      if (eob) begin
        do_clear = 1'b1;
      end else begin
        error_hold_next = 1'b1;
      end
    end
    if (do_clear) begin
      phase_next      = PH_KEY;
      acc_next        = 64'd0;
      vcount_next     = 4'd0;
      cur_field_next  = 29'd0;
      cur_wire_next   = 3'd0;
      bytes_left_next = 32'd0;
      error_hold_next = 1'b0;
    end

    res_valid        = do_fin || do_fail || do_emit;
    res.kind         = do_fail ? pbws_pkg::KIND_ERROR : out_kind;
    res.field_number = do_fail ? 29'd0 : cur_field;
    res.wire_type    = do_fail ? 3'd0 : cur_wire;
    res.field_value  = do_fail ? 64'd0 : out_value;
    res.payload_last = do_fail ? 1'b0 : out_last;
    res.error_code   = fail_code;
    res.buffer_done  = do_fail || (do_fin && eob);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_KEY;
      acc        <= 64'd0;
      vcount     <= 4'd0;
      cur_field  <= 29'd0;
      cur_wire   <= 3'd0;
      bytes_left <= 32'd0;
      error_hold <= 1'b0;
    end else begin
      phase      <= phase_next;
      acc        <= acc_next;
      vcount     <= vcount_next;
      cur_field  <= cur_field_next;
      cur_wire   <= cur_wire_next;
      bytes_left <= bytes_left_next;
      error_hold <= error_hold_next;
    end
  end

endmodule
`default_nettype wire

/* design/protobuf_wire_field_scanner_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// protobuf_wire_field_scanner_unit
// Byte-serial protocol-buffer wire-format field scanner.
// ----------------------------------------------------------------------------
// The unit takes one message byte per cycle, sustained, while the output is not
// stalled. Each accepted byte is captured in an input register; the scanner step
// then updates the field state and writes any result into the output register.
// The rate is set by that state update, which every byte passes through in
// order. While a result waits at the output, the input register still takes
// one more word and then holds it until the result is taken. No clearing pass
// follows reset.
module protobuf_wire_field_scanner_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  pbws_in_if.sink                              rx,
  pbws_out_if.source                           tx,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pbws_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready
);

  logic               in_full;
  pbws_pkg::in_word_t in_q;
  logic               out_full;
  pbws_pkg::result_t  out_q;
  logic               out_free;
  logic               fire;
  logic               res_valid;
  pbws_pkg::result_t  res;
  logic [31:0]        max_length;

  pbws_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_length (max_length)
  );

  pbws_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .in_word    (in_q),
    .max_length (max_length),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign out_free = !out_full || tx.ready;
  assign fire     = in_full && out_free;
  assign rx.ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (rx.valid && rx.ready) begin
        in_full <= 1'b1;
      end else if (fire) begin
        in_full <= 1'b0;
      end
      if (fire) begin
        out_full <= res_valid;
      end else if (tx.ready) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_q.data_byte     <= rx.data_byte;
      in_q.end_of_buffer <= rx.end_of_buffer;
    end
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  assign tx.valid        = out_full;
  assign tx.kind         = out_q.kind;
  assign tx.field_number = out_q.field_number;
  assign tx.wire_type    = out_q.wire_type;
  assign tx.field_value  = out_q.field_value;
  assign tx.payload_last = out_q.payload_last;
  assign tx.error_code   = out_q.error_code;
  assign tx.buffer_done  = out_q.buffer_done;

  // A buffered byte that cannot advance must still be held next cycle.
  a_in_kept: assert property (@(posedge clk) disable iff (rst)
    (in_full && !out_free) |=> in_full)
    else $error("input word dropped while output was stalled");

  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    (out_full && out_q.kind == pbws_pkg::KIND_ERROR) |->
      (out_q.buffer_done && out_q.field_value == 64'd0 && out_q.field_number == 29'd0))
    else $error("error result carries field data or does not close the buffer");

  a_last_on_byte: assert property (@(posedge clk) disable iff (rst)
    (out_full && out_q.payload_last) |->
      (out_q.kind == pbws_pkg::KIND_BYTE && out_q.error_code == pbws_pkg::ERR_NONE))
    else $error("payload_last set on a result that is not a payload byte");

endmodule
`default_nettype wire
